@@ design/spr_pkg.sv @@
// Package for the serial port register model: beat structs, request and
// register codes, and the fixed constants of the register file.
// No dependencies; used by spr_core and serial_port_register_model_top.
`default_nettype none

package spr_pkg;

    // Request codes carried in req_type
    localparam logic [2:0] REQ_READ      = 3'd0;
    localparam logic [2:0] REQ_WRITE     = 3'd1;
    localparam logic [2:0] REQ_TICK      = 3'd2;
    localparam logic [2:0] REQ_DEV_READY = 3'd3;
    localparam logic [2:0] REQ_SOFT_RST  = 3'd4;

    // Register offsets
    localparam logic [2:0] REG_RBR = 3'd0;  // RBR/THR, DLL with DLAB
    localparam logic [2:0] REG_IER = 3'd1;  // IER, DLM with DLAB
    localparam logic [2:0] REG_IIR = 3'd2;
    localparam logic [2:0] REG_LCR = 3'd3;
    localparam logic [2:0] REG_MCR = 3'd4;
    localparam logic [2:0] REG_LSR = 3'd5;
    localparam logic [2:0] REG_MSR = 3'd6;
    localparam logic [2:0] REG_SCR = 3'd7;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_READY  = 1'd1;

    localparam int unsigned CFG_DATA_W  = 33;
    localparam int unsigned BYTE_TIME_W = 33;
    localparam int unsigned TIME_LEFT_W = 35;

    localparam logic [BYTE_TIME_W-1:0] BYTE_TIME_RST = 33'd10000000;
    localparam logic [16:0] BYTE_NS_UNIT = 17'd69376;

    // Register values
    localparam logic [7:0] IIR_NONE    = 8'h01;
    localparam logic [7:0] IIR_OVERRUN = 8'h60;
    localparam logic [7:0] IIR_RX_DATA = 8'h40;
    localparam logic [7:0] LSR_RST     = 8'h60;
    localparam logic [7:0] LSR_RD_MASK = 8'hDE;  // drops DR and THRE
    localparam logic [7:0] LSR_OE      = 8'h02;
    localparam logic [7:0] LSR_THRE    = 8'h20;
    localparam logic [7:0] LCR_DLAB    = 8'h80;
    localparam logic [7:0] RX_NO_BYTE  = 8'hFF;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  reg_addr;
        logic [7:0]  write_data;
        logic [23:0] elapsed_ns;
        logic        dev_has_byte;
        logic [7:0]  dev_byte;
    } t_spr_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic       irq_pulse;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       dev_polled;
    } t_spr_out;

    // Configuration write as seen by the core
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_spr_cfg;

endpackage

`default_nettype wire

@@ design/spr_core.sv @@
// Register file and receive pacer of the serial port model: register state is
// updated once per accepted request beat, with the result computed alongside;
// byte time and tx_ready also take configuration writes. Depends on spr_pkg.
`default_nettype none

module spr_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire spr_pkg::t_spr_in i_req,
    input  wire spr_pkg::t_spr_cfg i_cfg,
    output spr_pkg::t_spr_out     o_res
);

    localparam int unsigned TLW = spr_pkg::TIME_LEFT_W;
    localparam int unsigned BTW = spr_pkg::BYTE_TIME_W;
    // one extra bit so the tick subtraction cannot wrap
    localparam int unsigned TW  = TLW + 1;
    localparam logic signed [TW-1:0] TL_MIN = -(TW'(1) <<< (TLW - 1));

    logic [7:0]           r_ier, n_ier;
    logic [7:0]           r_iir, n_iir;
    logic [7:0]           r_lcr, n_lcr;
    logic [7:0]           r_mcr, n_mcr;
    logic [7:0]           r_lsr, n_lsr;
    logic [7:0]           r_msr, n_msr;
    logic [7:0]           r_scr, n_scr;
    logic [15:0]          r_div, n_div;
    logic [BTW-1:0]       r_byte_time, n_byte_time;
    logic signed [TLW-1:0] r_time_left, n_time_left;
    logic [7:0]           r_rx_data, n_rx_data;
    logic                 r_rx_full, n_rx_full;
    logic                 r_rx_active, n_rx_active;
    logic                 r_tx_ready;

    logic                 dlab;
    logic                 div_wr;
    logic [32:0]          div_prod;
    logic signed [TW-1:0] t_sub, t_sub_sat, t_add, t_add_sat;

    assign dlab = (r_lcr & spr_pkg::LCR_DLAB) != 8'h00;

    // Byte timer arithmetic for a tick
    always_comb begin
        t_sub     = TW'(r_time_left) - $signed({{(TW-24){1'b0}}, i_req.elapsed_ns});
        t_sub_sat = (t_sub < TL_MIN) ? TL_MIN : t_sub;
        t_add     = t_sub_sat + $signed({{(TW-BTW){1'b0}}, r_byte_time});
        t_add_sat = (t_add < TL_MIN) ? TL_MIN : t_add;
    end

    // Byte time from the divisor latch
    assign div_prod = spr_pkg::BYTE_NS_UNIT * n_div;

    // Next state and result
    always_comb begin
        n_ier       = r_ier;
        n_iir       = r_iir;
        n_lcr       = r_lcr;
        n_mcr       = r_mcr;
        n_lsr       = r_lsr;
        n_msr       = r_msr;
        n_scr       = r_scr;
        n_div       = r_div;
        n_time_left = r_time_left;
        n_rx_data   = r_rx_data;
        n_rx_full   = r_rx_full;
        n_rx_active = r_rx_active;
        div_wr      = 1'b0;
        o_res       = '0;

        case (i_req.req_type)
            spr_pkg::REQ_READ: begin
                o_res.read_valid = 1'b1;
                case (i_req.reg_addr)
                    spr_pkg::REG_RBR: begin
                        if (dlab) begin
                            o_res.read_data = r_div[7:0];
                        end else if (r_rx_full) begin
                            o_res.read_data = r_rx_data;
                            n_rx_full       = 1'b0;
                            n_iir           = spr_pkg::IIR_NONE;
                        end else begin
                            o_res.read_valid = 1'b0;
                        end
                    end
                    spr_pkg::REG_IER: o_res.read_data = dlab ? r_div[15:8] : r_ier;
                    spr_pkg::REG_IIR: o_res.read_data = {5'b0, r_iir[2:0]};
                    spr_pkg::REG_LCR: o_res.read_data = r_lcr;
                    spr_pkg::REG_MCR: o_res.read_data = r_mcr;
                    spr_pkg::REG_LSR: begin
                        o_res.read_data = (r_lsr & spr_pkg::LSR_RD_MASK)
                                        | {7'b0, r_rx_full}
                                        | (r_tx_ready ? spr_pkg::LSR_THRE : 8'h00);
                    end
                    spr_pkg::REG_MSR: begin
                        o_res.read_data = r_msr;
                        if (r_iir == 8'h00) begin
                            n_iir = spr_pkg::IIR_NONE;
                        end
                    end
                    default: o_res.read_data = r_scr;
                endcase
            end
            spr_pkg::REQ_WRITE: begin
                case (i_req.reg_addr)
                    spr_pkg::REG_RBR: begin
                        if (dlab) begin
                            n_div  = {r_div[15:8], i_req.write_data};
                            div_wr = 1'b1;
                        end else if (r_tx_ready) begin
                            n_iir          = spr_pkg::IIR_NONE;
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = i_req.write_data;
                        end
                    end
                    spr_pkg::REG_IER: begin
                        if (dlab) begin
                            n_div  = {i_req.write_data, r_div[7:0]};
                            div_wr = 1'b1;
                        end else begin
                            n_ier = i_req.write_data;
                        end
                    end
                    spr_pkg::REG_LCR: n_lcr = i_req.write_data;
                    spr_pkg::REG_MCR: n_mcr = i_req.write_data;
                    spr_pkg::REG_LSR: n_lsr = i_req.write_data;
                    spr_pkg::REG_MSR: n_msr = i_req.write_data;
                    spr_pkg::REG_SCR: n_scr = i_req.write_data;
                    default: ;  // IIR is read-only
                endcase
            end
            spr_pkg::REQ_TICK: begin
                if (r_rx_active) begin
                    n_time_left = t_sub_sat[TLW-1:0];
                    if (t_sub_sat < 0) begin
                        n_time_left      = t_add_sat[TLW-1:0];
                        o_res.dev_polled = 1'b1;
                        if (!i_req.dev_has_byte) begin
                            // device idle: reception stops
                            n_rx_data   = spr_pkg::RX_NO_BYTE;
                            n_rx_active = 1'b0;
                            n_time_left = '0;
                        end else begin
                            n_rx_data = i_req.dev_byte;
                            if (r_rx_full) begin
                                n_lsr = r_lsr | spr_pkg::LSR_OE;
                                n_iir = spr_pkg::IIR_OVERRUN;
                            end else begin
                                n_rx_full = 1'b1;
                                n_iir     = spr_pkg::IIR_RX_DATA;
                            end
                            o_res.irq_pulse = r_ier[0];
                        end
                    end
                end
            end
            spr_pkg::REQ_DEV_READY: begin
                n_rx_active = 1'b1;
                n_lsr       = 8'h00;
            end
            spr_pkg::REQ_SOFT_RST: begin
                n_ier = 8'h00;
                n_iir = spr_pkg::IIR_NONE;
                n_lcr = 8'h00;
                n_mcr = 8'h00;
                n_lsr = spr_pkg::LSR_RST;
                n_msr = 8'h00;
            end
            default: ;  // unused request codes do nothing
        endcase
    end

    // Byte time source: divisor write on a beat, else a config write
    always_comb begin
        n_byte_time = r_byte_time;
        if (i_fire && div_wr) begin
            n_byte_time = div_prod[BTW-1:0];
        end else if (i_cfg.we && i_cfg.idx == spr_pkg::CFG_BYTE_TIME) begin
            n_byte_time = i_cfg.data[BTW-1:0];
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ier       <= 8'h00;
            r_iir       <= spr_pkg::IIR_NONE;
            r_lcr       <= 8'h00;
            r_mcr       <= 8'h00;
            r_lsr       <= spr_pkg::LSR_RST;
            r_msr       <= 8'h00;
            r_scr       <= 8'h00;
            r_div       <= 16'h0000;
            r_byte_time <= spr_pkg::BYTE_TIME_RST;
            r_time_left <= '0;
            r_rx_data   <= 8'h00;
            r_rx_full   <= 1'b0;
            r_rx_active <= 1'b0;
            r_tx_ready  <= 1'b0;
        end else begin
            r_byte_time <= n_byte_time;
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    spr_pkg::CFG_TX_READY: r_tx_ready <= i_cfg.data[0];
                    default: ;  // byte time is loaded above
                endcase
            end
            if (i_fire) begin
                r_ier       <= n_ier;
                r_iir       <= n_iir;
                r_lcr       <= n_lcr;
                r_mcr       <= n_mcr;
                r_lsr       <= n_lsr;
                r_msr       <= n_msr;
                r_scr       <= n_scr;
                r_div       <= n_div;
                r_time_left <= n_time_left;
                r_rx_data   <= n_rx_data;
                r_rx_full   <= n_rx_full;
                r_rx_active <= n_rx_active;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/serial_port_register_model_top.sv @@
// Top level of the serial port register model: request/result channels
// with a registered result stage, plus the configuration write port.
// Depends on spr_pkg and spr_core.
//
// Usage:
//   Request beats (i_in_valid/o_in_ready, payload i_in) carry register
//   reads and writes, time ticks, device-ready events and soft resets.
//   Each request produces exactly one result beat (o_out_valid/
//   i_out_ready, payload o_out).
//   The result of an accepted beat is offered from the next cycle on.
//   Throughput is one beat per cycle while results are taken;
//   all register and timer updates are done in the cycle of acceptance.
//   When the receiver stalls, the result register holds its beat and
//   o_in_ready drops until the result is taken; a request is accepted in
//   the same cycle the held result leaves.
//   Reset (i_rst_n low at a clock edge) loads all registers to their
//   power-on values, the byte time to 10000000 ns and tx_ready to 0,
//   and empties the result stage. Configuration writes (i_cfg_we) take
//   effect at the edge where they are given.
`default_nettype none

module serial_port_register_model_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire spr_pkg::t_spr_in                  i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output spr_pkg::t_spr_out                      o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [spr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [spr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic              fire;
    logic              r_out_valid;
    spr_pkg::t_spr_out r_out;
    spr_pkg::t_spr_out core_res;
    spr_pkg::t_spr_cfg cfg;

    // Result stage frees up when empty or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    spr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (i_in),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
